// ----- hw/rtl/note_track_voice_allocator_defines.svh -----
// assertion macros for the note track voice allocator
// used by the queue and the back end; no other dependencies
`ifndef NOTE_TRACK_VOICE_ALLOCATOR_DEFINES_SVH
`define NOTE_TRACK_VOICE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NTVA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntva assertion failed");

// next-cycle implication
`define NTVA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntva assertion failed");

`else

`define NTVA_ASSERT_IMP(name, clk, rst, ante, cons)
`define NTVA_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/ntva_pkg.sv -----
// types, constants and helpers shared by the voice allocator modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ntva_pkg;

  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned INSTR_W = 8;
  localparam int unsigned TRACK_W = 5;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned BYTE_W  = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned DEF_MAX_TRACK_COUNT = 32;
  localparam int unsigned QUEUE_DEPTH         = 2;

  localparam logic [NOTE_W-1:0]  FREE_NOTE  = 7'd120;
  localparam logic [NOTE_W-1:0]  NOFF_NOTE  = 7'd120;
  localparam logic [NOTE_W-1:0]  TOP_NOTE   = 7'd119;
  localparam logic [VEL_W-1:0]   NO_MAP_VEL = 7'd127;
  localparam logic [INSTR_W-1:0] DEF_INSTR  = 8'd255;
  localparam logic [8:0]         OCT_SEMIS  = 9'd12;

  // floor(a / 127) == (a * RECIP_127) >> RECIP_SHIFT for a below 2**15
  localparam logic [15:0] RECIP_127   = 16'd33027;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam logic       OP_STOP = 1'b1;
  localparam logic [1:0] VM_CMD  = 2'd1;
  localparam logic [1:0] VM_INS  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK_COUNT = 3'd0,
    CFG_MULTI_KEY   = 3'd1,
    CFG_OCTAVE      = 3'd2,
    CFG_DEF_INSTR   = 3'd3,
    CFG_VEL_MODE    = 3'd4,
    CFG_VEL_FROM    = 3'd5,
    CFG_VEL_TO      = 3'd6,
    CFG_VEL_CMD     = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [5:0]         track_count;
    logic               multi_key;
    logic [3:0]         octave;
    logic [INSTR_W-1:0] default_instrument;
    logic [1:0]         velocity_mode;
    logic [BYTE_W-1:0]  velocity_from;
    logic [BYTE_W-1:0]  velocity_to;
    logic [BYTE_W-1:0]  velocity_command;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    track_count:        6'd16,
    multi_key:          1'b1,
    octave:             4'd4,
    default_instrument: 8'd0,
    velocity_mode:      2'd0,
    velocity_from:      8'd0,
    velocity_to:        8'd255,
    velocity_command:   8'd12
  };

  typedef struct packed {
    logic               op;
    logic [NOTE_W-1:0]  note_in;
    logic [INSTR_W-1:0] instrument_in;
    logic [VEL_W-1:0]   velocity;
    logic               transpose;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [NOTE_W-1:0]  note_out;
    logic [INSTR_W-1:0] instrument_out;
    logic [BYTE_W-1:0]  command;
    logic [BYTE_W-1:0]  parameter_res;
    logic               last;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               op;
    logic [NOTE_W-1:0]  note;
    logic [INSTR_W-1:0] ins;
    logic [INSTR_W-1:0] out_ins;
    logic [BYTE_W-1:0]  command;
    logic [BYTE_W-1:0]  param;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_NOTEON,
    B_FINISH
  } back_state_t;

  typedef enum logic [1:0] {
    PH_STOP1,
    PH_SEARCH,
    PH_PEEK,
    PH_STOP2
  } scan_phase_t;

  function automatic logic [INSTR_W-1:0] pick_instr(input logic [INSTR_W-1:0] ins,
                                                    input logic [INSTR_W-1:0] dflt);
    return (ins != DEF_INSTR) ? ins : dflt;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/note_track_voice_allocator.sv -----
// the back end takes one item at a time and walks the tracks in use through its
// one-port track table: a stop item needs a stop scan; a play item adds a free-track
// search (multi key only), a peek at the target and, if that track sounds, a second stop scan
// the front end takes the next item while the back end works, up to a queue of two
// reset: registers to defaults, every track free, last track zero; results are never held off
`timescale 1ns / 1ps
`default_nettype none

module note_track_voice_allocator import ntva_pkg::*; #(
  parameter int unsigned MAX_TRACK_COUNT = DEF_MAX_TRACK_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              item,
  output logic                       result_strobe,
  output result_t                    result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_idx))
        CFG_TRACK_COUNT: cfg.track_count        <= cfg_wdata[5:0];
        CFG_MULTI_KEY:   cfg.multi_key          <= cfg_wdata[0];
        CFG_OCTAVE:      cfg.octave             <= cfg_wdata[3:0];
        CFG_DEF_INSTR:   cfg.default_instrument <= cfg_wdata;
        CFG_VEL_MODE:    cfg.velocity_mode      <= cfg_wdata[1:0];
        CFG_VEL_FROM:    cfg.velocity_from      <= cfg_wdata;
        CFG_VEL_TO:      cfg.velocity_to        <= cfg_wdata;
        CFG_VEL_CMD:     cfg.velocity_command   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ntva_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  ntva_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ntva_back #(
    .MAX_TRACK_COUNT (MAX_TRACK_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ntva_front.sv -----
// front end: takes an item, transposes it, maps velocity and pushes a command
// depends on ntva_pkg
`timescale 1ns / 1ps
`default_nettype none

module ntva_front import ntva_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     start,
  input  wire in_item_t item,
  output logic          busy,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          push_data
);

  front_state_t state, state_next;

  logic               op_q;
  logic [NOTE_W-1:0]  note_q;
  logic [INSTR_W-1:0] ins_q;
  logic [VEL_W-1:0]   vel_q;
  logic signed [16:0] prod;
  logic [7:0]         quot;
  logic               neg;

  logic [8:0]         note_sum;
  logic [NOTE_W-1:0]  note_x;
  logic signed [8:0]  diff;
  logic signed [16:0] diff_x;
  logic signed [16:0] vel_x;
  logic signed [16:0] mag_x;
  logic [30:0]        qprod;
  logic signed [10:0] from_s;
  logic signed [10:0] q_s;
  logic signed [10:0] m_s;
  logic [7:0]         mapped;
  logic               map_on;

  // transposition: only notes below the special range move
  always_comb begin
    note_sum = 9'(item.note_in) + 9'(cfg.octave) * OCT_SEMIS;
    if (item.note_in >= FREE_NOTE) begin
      note_x = item.note_in;
    end else if (!item.transpose) begin
      note_x = item.note_in;
    end else if (note_sum > 9'(TOP_NOTE)) begin
      note_x = TOP_NOTE;
    end else begin
      note_x = note_sum[NOTE_W-1:0];
    end
  end

  always_comb begin
    diff   = $signed({1'b0, cfg.velocity_to}) - $signed({1'b0, cfg.velocity_from});
    diff_x = 17'(diff);
    vel_x  = $signed(17'(vel_q));
    mag_x  = prod[16] ? -prod : prod;
    qprod  = 31'(mag_x[14:0]) * 31'(RECIP_127);
  end

  // from + trunc((to - from) * vel / 127), limited to a byte
  always_comb begin
    from_s = $signed(11'(cfg.velocity_from));
    q_s    = $signed(11'(quot));
    m_s    = neg ? (from_s - q_s) : (from_s + q_s);
    if (m_s < 0) begin
      mapped = 8'd0;
    end else if (m_s > 11'sd255) begin
      mapped = 8'd255;
    end else begin
      mapped = m_s[7:0];
    end
    map_on = (vel_q != NO_MAP_VEL) &&
             ((cfg.velocity_mode == VM_CMD) || (cfg.velocity_mode == VM_INS));
  end

  always_comb begin
    push_data.op      = op_q;
    push_data.note    = note_q;
    push_data.ins     = ins_q;
    push_data.out_ins = (map_on && cfg.velocity_mode == VM_INS) ? mapped : ins_q;
    push_data.command = (map_on && cfg.velocity_mode == VM_CMD) ? cfg.velocity_command : '0;
    push_data.param   = (map_on && cfg.velocity_mode == VM_CMD) ? mapped : '0;
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (start) begin
          state_next = F_MUL;
        end
      end
      F_MUL: begin
        state_next = F_DIV;
      end
      F_DIV: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assign busy = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      op_q   <= item.op;
      note_q <= note_x;
      ins_q  <= pick_instr(item.instrument_in, cfg.default_instrument);
      vel_q  <= item.velocity;
    end
    if (state == F_MUL) begin
      prod <= diff_x * vel_x;
    end
    if (state == F_DIV) begin
      quot <= 8'(qprod >> RECIP_SHIFT);
      neg  <= prod[16];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ntva_queue.sv -----
// short command queue between front and back end
// depends on ntva_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "note_track_voice_allocator_defines.svh"

module ntva_queue import ntva_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : PW'(32'(p) + 1);
  endfunction

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `NTVA_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `NTVA_ASSERT_NXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

`default_nettype wire

// ----- hw/rtl/ntva_back.sv -----
// back end: track table, stop/search/steal scans and result sequencing
// depends on ntva_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "note_track_voice_allocator_defines.svh"

module ntva_back import ntva_pkg::*; #(
  parameter int unsigned MAX_TRACK_COUNT = DEF_MAX_TRACK_COUNT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_empty,
  input  wire cmd_t q_data,
  output logic      q_pop,
  output logic      result_strobe,
  output result_t   result
);

  localparam int unsigned IDXW = (MAX_TRACK_COUNT > 1) ? $clog2(MAX_TRACK_COUNT) : 1;
  localparam int unsigned CNTW = $clog2(MAX_TRACK_COUNT + 1);
  localparam int unsigned WW   = CNTW + 1;

  back_state_t state, state_next;
  scan_phase_t phase, phase_next;

  cmd_t               cur, cur_next;
  logic [NOTE_W-1:0]  key_note, key_note_next;
  logic [INSTR_W-1:0] key_ins, key_ins_next;
  logic [IDXW-1:0]    issue_idx, issue_idx_next;
  logic [CNTW-1:0]    issue_cnt, issue_cnt_next;
  logic               rd_vld, rd_vld_next;
  logic [IDXW-1:0]    rd_idx, rd_idx_next;
  logic               found, found_next;
  logic [IDXW-1:0]    tgt, tgt_next;
  logic               steal, steal_next;
  logic [IDXW-1:0]    last_track, last_track_next;
  logic               pend_vld, pend_vld_next;
  result_t            pend, pend_next;
  logic               out_vld, out_vld_next;
  result_t            out_res, out_res_next;

  // track table; a track without its valid bit reads as free
  logic [NOTE_W-1:0]          mem_note [MAX_TRACK_COUNT];
  logic [INSTR_W-1:0]         mem_ins  [MAX_TRACK_COUNT];
  logic [MAX_TRACK_COUNT-1:0] ent_vld;
  logic [NOTE_W-1:0]          rd_note;
  logic [INSTR_W-1:0]         rd_ins;
  logic                       rd_ent;

  logic               mem_re, mem_we, vld_clr;
  logic               emit_req;
  result_t            emit_res;
  logic               scan_done;
  logic [CNTW-1:0]    tc_eff;
  logic [WW-1:0]      nxt_wide, lt_wide;
  logic [IDXW-1:0]    search_start;
  logic [NOTE_W-1:0]  hn;
  logic [INSTR_W-1:0] hi;

  always_comb begin
    if (cfg.track_count == '0) begin
      tc_eff = CNTW'(1);
    end else if (7'(cfg.track_count) > 7'(MAX_TRACK_COUNT)) begin
      tc_eff = CNTW'(MAX_TRACK_COUNT);
    end else begin
      tc_eff = CNTW'(cfg.track_count);
    end
    nxt_wide = WW'(issue_idx) + WW'(1);
    lt_wide  = WW'(last_track) + WW'(1);
    // round robin starts after the last track, or at zero when that is out of range
    search_start = (lt_wide < WW'(tc_eff)) ? IDXW'(lt_wide) : '0;
    hn = rd_ent ? rd_note : FREE_NOTE;
    hi = rd_ent ? rd_ins : DEF_INSTR;
  end

  assign mem_re    = (state == B_SCAN) && (issue_cnt != '0) && !found;
  assign scan_done = ((issue_cnt == '0) || found) && !rd_vld;

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    cur_next        = cur;
    key_note_next   = key_note;
    key_ins_next    = key_ins;
    issue_idx_next  = issue_idx;
    issue_cnt_next  = issue_cnt;
    rd_vld_next     = 1'b0;
    rd_idx_next     = rd_idx;
    found_next      = found;
    tgt_next        = tgt;
    steal_next      = steal;
    last_track_next = last_track;
    pend_vld_next   = pend_vld;
    pend_next       = pend;
    out_vld_next    = 1'b0;
    out_res_next    = out_res;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    vld_clr         = 1'b0;
    emit_req        = 1'b0;
    emit_res        = '0;

    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          cur_next       = q_data;
          key_note_next  = q_data.note;
          key_ins_next   = q_data.ins;
          state_next     = B_SCAN;
          phase_next     = PH_STOP1;
          issue_idx_next = '0;
          issue_cnt_next = tc_eff;
          found_next     = 1'b0;
        end
      end

      B_SCAN: begin
        // address stage
        if (mem_re) begin
          rd_vld_next    = 1'b1;
          rd_idx_next    = issue_idx;
          issue_cnt_next = issue_cnt - CNTW'(1);
          issue_idx_next = (nxt_wide == WW'(tc_eff)) ? '0 : IDXW'(nxt_wide);
        end
        // data stage
        if (rd_vld) begin
          case (phase)
            PH_STOP1, PH_STOP2: begin
              if (hn == key_note && hi == key_ins) begin
                vld_clr                 = 1'b1;
                emit_req                = 1'b1;
                emit_res.track          = TRACK_W'(rd_idx);
                emit_res.note_out       = NOFF_NOTE;
                emit_res.instrument_out = key_ins;
              end
            end
            PH_SEARCH: begin
              if (!found && hn == FREE_NOTE) begin
                found_next = 1'b1;
                tgt_next   = rd_idx;
              end
            end
            PH_PEEK: begin
              // a sounding track is stopped as held, no second transposition
              steal_next    = (hn < FREE_NOTE);
              key_note_next = hn;
              key_ins_next  = pick_instr(hi, cfg.default_instrument);
            end
            default: begin
            end
          endcase
        end
        // phase change once the last read has drained
        if (scan_done) begin
          case (phase)
            PH_STOP1: begin
              if (cur.op == OP_STOP) begin
                state_next = B_FINISH;
              end else if (cfg.multi_key) begin
                phase_next     = PH_SEARCH;
                issue_idx_next = search_start;
                issue_cnt_next = tc_eff;
                found_next     = 1'b0;
                tgt_next       = '0;
              end else begin
                phase_next     = PH_PEEK;
                tgt_next       = '0;
                issue_idx_next = '0;
                issue_cnt_next = CNTW'(1);
              end
            end
            PH_SEARCH: begin
              // no free track leaves the target at zero
              phase_next     = PH_PEEK;
              issue_idx_next = tgt;
              issue_cnt_next = CNTW'(1);
              found_next     = 1'b0;
            end
            PH_PEEK: begin
              if (steal) begin
                phase_next     = PH_STOP2;
                issue_idx_next = '0;
                issue_cnt_next = tc_eff;
              end else begin
                state_next = B_NOTEON;
              end
            end
            PH_STOP2: begin
              state_next = B_NOTEON;
            end
            default: begin
              state_next = B_FINISH;
            end
          endcase
        end
      end

      B_NOTEON: begin
        mem_we                  = 1'b1;
        last_track_next         = tgt;
        emit_req                = 1'b1;
        emit_res.track          = TRACK_W'(tgt);
        emit_res.note_out       = cur.note;
        emit_res.instrument_out = cur.out_ins;
        emit_res.command        = cur.command;
        emit_res.parameter_res  = cur.param;
        state_next              = B_FINISH;
      end

      B_FINISH: begin
        if (pend_vld) begin
          out_vld_next      = 1'b1;
          out_res_next      = pend;
          out_res_next.last = 1'b1;
          pend_vld_next     = 1'b0;
        end
        state_next = B_IDLE;
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase

    // one result held back so the final one can carry the last flag
    if (emit_req) begin
      if (pend_vld) begin
        out_vld_next = 1'b1;
        out_res_next = pend;
      end
      pend_next     = emit_res;
      pend_vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_note[tgt] <= cur.note;
      mem_ins[tgt]  <= cur.ins;
    end
    if (mem_re) begin
      rd_note <= mem_note[issue_idx];
      rd_ins  <= mem_ins[issue_idx];
      rd_ent  <= ent_vld[issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else begin
      if (mem_we) begin
        ent_vld[tgt] <= 1'b1;
      end
      if (vld_clr) begin
        ent_vld[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      phase      <= PH_STOP1;
      issue_cnt  <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      last_track <= '0;
      pend_vld   <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      issue_cnt  <= issue_cnt_next;
      rd_vld     <= rd_vld_next;
      found      <= found_next;
      last_track <= last_track_next;
      pend_vld   <= pend_vld_next;
      out_vld    <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    key_note  <= key_note_next;
    key_ins   <= key_ins_next;
    issue_idx <= issue_idx_next;
    rd_idx    <= rd_idx_next;
    tgt       <= tgt_next;
    steal     <= steal_next;
    pend      <= pend_next;
    out_res   <= out_res_next;
  end

  assign result_strobe = out_vld;
  assign result        = out_res;

  `NTVA_ASSERT_IMP(a_idle_no_pending, clk, rst, state == B_IDLE, !pend_vld)
  `NTVA_ASSERT_IMP(a_last_then_idle, clk, rst, out_vld && out_res.last, state == B_IDLE)
  `NTVA_ASSERT_IMP(a_target_in_range, clk, rst, state == B_SCAN && phase == PH_SEARCH && found, WW'(tgt) < WW'(tc_eff))

endmodule

`default_nettype wire

// ----- tb/tb_note_track_voice_allocator.sv -----
// self-checking testbench for note_track_voice_allocator: key events in, track events out
// predicts every track event from its own copy of the track table and registers
// depends on ntva_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_note_track_voice_allocator;
  import ntva_pkg::*;

  localparam int TRACK_SLOTS   = DEF_MAX_TRACK_COUNT;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 288;
  localparam int HISTORY_DEPTH = 8;
  localparam int ITEM_W        = $bits(in_item_t);

  localparam logic       OP_PLAY   = 1'b0;
  localparam logic [1:0] VM_OFF    = 2'd0;
  localparam logic [1:0] VM_UNUSED = 2'd3;

  // predicted track table plus the queue of track events still to arrive
  class track_event_scoreboard;
    cfg_t              regs;
    logic [NOTE_W-1:0] held_note[TRACK_SLOTS];
    logic [INSTR_W-1:0] held_ins[TRACK_SLOTS];
    int unsigned       last_trk;
    result_t           pending[$];
    int                errors;

    function new();
      regs = CFG_RESET;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        held_note[i] = FREE_NOTE;
        held_ins[i]  = DEF_INSTR;
      end
      last_trk = 0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_TRACK_COUNT: regs.track_count        = v[5:0];
        CFG_MULTI_KEY:   regs.multi_key          = v[0];
        CFG_OCTAVE:      regs.octave             = v[3:0];
        CFG_DEF_INSTR:   regs.default_instrument = v;
        CFG_VEL_MODE:    regs.velocity_mode      = v[1:0];
        CFG_VEL_FROM:    regs.velocity_from      = v;
        CFG_VEL_TO:      regs.velocity_to        = v;
        CFG_VEL_CMD:     regs.velocity_command   = v;
        default: ;
      endcase
    endfunction

    function int unsigned tracks_in_use();
      int unsigned tc;
      tc = regs.track_count;
      if (tc == 0) tc = 1;
      if (tc > TRACK_SLOTS) tc = TRACK_SLOTS;
      return tc;
    endfunction

    function logic [INSTR_W-1:0] resolve_instr(logic [INSTR_W-1:0] ins);
      return (ins != DEF_INSTR) ? ins : regs.default_instrument;
    endfunction

    function void emit(int unsigned trk, logic [NOTE_W-1:0] note, logic [INSTR_W-1:0] ins,
                       logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] par);
      result_t r;
      r.track          = trk[TRACK_W-1:0];
      r.note_out       = note;
      r.instrument_out = ins;
      r.command        = cmd;
      r.parameter_res  = par;
      r.last           = 1'b0;
      pending.push_back(r);
    endfunction

    // note-off and free every track holding this note and instrument
    function void release_matching(logic [NOTE_W-1:0] note, logic [INSTR_W-1:0] ins);
      int unsigned tc;
      tc = tracks_in_use();
      for (int unsigned i = 0; i < tc; i++) begin
        if (held_note[i] == note && held_ins[i] == ins) begin
          held_note[i] = FREE_NOTE;
          held_ins[i]  = DEF_INSTR;
          emit(i, NOFF_NOTE, ins, '0, '0);
        end
      end
    endfunction

    function void note_key_event(in_item_t it);
      int unsigned        note, tc, t;
      int                 from, m;
      logic [INSTR_W-1:0] ins, out_ins;
      logic [BYTE_W-1:0]  cmd, par;
      bit                 found;
      int                 n0;
      result_t            r;
      n0      = pending.size();
      tc      = tracks_in_use();
      ins     = resolve_instr(it.instrument_in);
      out_ins = ins;
      cmd     = '0;
      par     = '0;
      found   = 1'b0;
      t       = 0;
      note    = it.note_in;
      // notes 120 and up are commands and never transposed
      if (note < FREE_NOTE) begin
        if (it.transpose) note = note + regs.octave * 12;
        if (note > TOP_NOTE) note = TOP_NOTE;
      end
      release_matching(note[NOTE_W-1:0], ins);
      if (it.op == OP_PLAY) begin
        if (it.velocity != NO_MAP_VEL &&
            (regs.velocity_mode == VM_CMD || regs.velocity_mode == VM_INS)) begin
          from = int'(regs.velocity_from);
          m = from + ((int'(regs.velocity_to) - from) * int'(it.velocity)) / 127;
          if (m > 255) m = 255;
          if (m < 0) m = 0;
          if (regs.velocity_mode == VM_CMD) begin
            cmd = regs.velocity_command;
            par = m[7:0];
          end else begin
            out_ins = m[7:0];
          end
        end
        if (regs.multi_key) begin
          for (int unsigned i = last_trk + 1; i < tc; i++) begin
            if (!found && held_note[i] == FREE_NOTE) begin
              t     = i;
              found = 1'b1;
            end
          end
          // wrap around, falls back to track zero when all are busy
          for (int unsigned i = 0; i <= last_trk && i < tc; i++) begin
            if (!found && held_note[i] == FREE_NOTE) begin
              t     = i;
              found = 1'b1;
            end
          end
        end
        last_trk = t;
        // steal: stop the held note as held, no second transposition
        if (held_note[t] < FREE_NOTE) release_matching(held_note[t], resolve_instr(held_ins[t]));
        held_note[t] = note[NOTE_W-1:0];
        held_ins[t]  = ins;
        emit(t, note[NOTE_W-1:0], out_ins, cmd, par);
      end
      if (pending.size() > n0) begin
        r = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_track_event(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected track event, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("track", want.track, got.track);
      compare_field("note_out", want.note_out, got.note_out);
      compare_field("instrument_out", want.instrument_out, got.instrument_out);
      compare_field("command", want.command, got.command);
      compare_field("parameter_res", want.parameter_res, got.parameter_res);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              item      = '0;
  logic                  result_strobe;
  result_t               result;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  track_event_scoreboard sb = new();
  int                    cycles = 0;
  int                    items_sent = 0;
  bit                    quiet_phase = 1'b0;
  in_item_t              played[HISTORY_DEPTH];
  int                    played_n = 0;
  int                    played_wr = 0;

  note_track_voice_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_track_event(result);
  end

  function automatic in_item_t key_event(logic op, int note, int ins, int vel, logic tr);
    in_item_t it;
    it.op            = op;
    it.note_in       = note[NOTE_W-1:0];
    it.instrument_in = ins[INSTR_W-1:0];
    it.velocity      = vel[VEL_W-1:0];
    it.transpose     = tr;
    return it;
  endfunction

  // mostly back to back or short, now and then a long gap
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t random_key_event();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it = in_item_t'(ITEM_W'($urandom));
    end else if (r < 40 && played_n > 0) begin
      // stop a note that was played recently
      it          = played[$urandom_range(0, played_n - 1)];
      it.op       = OP_STOP;
      it.velocity = VEL_W'($urandom_range(0, 127));
    end else begin
      it.op = OP_PLAY;
      if ($urandom_range(0, 9) == 0) it.note_in = NOTE_W'($urandom_range(120, 127));
      else it.note_in = NOTE_W'($urandom_range(0, 9) * 13);
      case ($urandom_range(0, 3))
        0: it.instrument_in = 8'd0;
        1: it.instrument_in = 8'd1;
        2: it.instrument_in = 8'd254;
        default: it.instrument_in = DEF_INSTR;
      endcase
      it.velocity  = ($urandom_range(0, 2) == 0) ? NO_MAP_VEL : VEL_W'($urandom_range(0, 127));
      it.transpose = 1'($urandom_range(0, 1));
      played[played_wr] = it;
      played_wr = (played_wr + 1) % HISTORY_DEPTH;
      if (played_n < HISTORY_DEPTH) played_n++;
    end
    return it;
  endfunction

  task automatic pause_sender(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_key_event(it);
    items_sent++;
    pause_sender(gap_len());
  endtask

  task automatic wait_results_done();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // start is already low or lowered here; stop items leave no trace, so settle after
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic program_regs(logic [7:0] tc, logic [7:0] mk, logic [7:0] oct,
                              logic [7:0] dflt, logic [7:0] vm, logic [7:0] vf,
                              logic [7:0] vt, logic [7:0] vc);
    write_reg(CFG_TRACK_COUNT, tc);
    write_reg(CFG_MULTI_KEY, mk);
    write_reg(CFG_OCTAVE, oct);
    write_reg(CFG_DEF_INSTR, dflt);
    write_reg(CFG_VEL_MODE, vm);
    write_reg(CFG_VEL_FROM, vf);
    write_reg(CFG_VEL_TO, vt);
    write_reg(CFG_VEL_CMD, vc);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_random_regs();
    int r;
    logic [7:0] tc;
    r = $urandom_range(0, 99);
    if (r < 70) tc = 8'($urandom_range(1, 6));
    else if (r < 90) tc = 8'($urandom_range(7, 32));
    else tc = 8'($urandom_range(0, 63));
    program_regs(tc, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: extremes of note, instrument, velocity and transpose
    send_item(key_event(OP_PLAY, 0, 0, 127, 1'b0));
    send_item(key_event(OP_PLAY, 119, 254, 0, 1'b1));
    send_item(key_event(OP_PLAY, 127, 255, 126, 1'b1));
    send_item(key_event(OP_PLAY, 120, 10, 127, 1'b1));
    send_item(key_event(OP_PLAY, 60, 3, 127, 1'b1));
    send_item(key_event(OP_PLAY, 60, 3, 127, 1'b1));
    send_item(key_event(OP_STOP, 60, 3, 5, 1'b1));
    send_item(key_event(OP_STOP, 61, 3, 127, 1'b1));
    send_item(key_event(OP_STOP, 127, 255, 127, 1'b0));
    drain();

    // two tracks, all busy: wrap to track zero, steal, held command note overwritten
    program_regs(2, 1, 0, 255, VM_CMD, 200, 10, 8'h5a);
    send_item(key_event(OP_PLAY, 10, 255, 0, 1'b0));
    send_item(key_event(OP_PLAY, 11, 7, 64, 1'b0));
    send_item(key_event(OP_PLAY, 12, 7, 126, 1'b1));
    send_item(key_event(OP_PLAY, 121, 9, 127, 1'b0));
    send_item(key_event(OP_PLAY, 13, 9, 1, 1'b0));
    send_item(key_event(OP_STOP, 120, 255, 127, 1'b0));
    drain();

    // track count zero, single key, instrument from velocity, top octave
    program_regs(0, 0, 15, 0, VM_INS, 255, 0, 0);
    send_item(key_event(OP_PLAY, 5, 1, 100, 1'b1));
    send_item(key_event(OP_PLAY, 6, 2, 0, 1'b0));
    send_item(key_event(OP_STOP, 6, 2, 127, 1'b0));
    drain();

    // track count above the maximum, unused velocity mode
    program_regs(63, 1, 1, 3, VM_UNUSED, 0, 255, 12);
    send_item(key_event(OP_PLAY, 30, 4, 10, 1'b1));
    send_item(key_event(OP_PLAY, 31, 4, 20, 1'b1));
    send_item(key_event(OP_PLAY, 32, 4, 30, 1'b1));
    drain();

    // last track now beyond the track count
    program_regs(2, 1, 4, 0, VM_OFF, 0, 255, 12);
    send_item(key_event(OP_PLAY, 40, 5, 127, 1'b0));
    send_item(key_event(OP_PLAY, 41, 5, 127, 1'b0));
    drain();

    items_sent = 0;
    program_regs(32, 1, 9, 254, VM_CMD, 0, 255, 255);
    while (items_sent < RANDOM_ITEMS) begin
      phase_len   = $urandom_range(20, 50);
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (items_sent < RANDOM_ITEMS) begin
          send_item(random_key_event());
          if ($urandom_range(0, 19) == 0) begin
            start <= 1'b0;
            @(posedge clk);
            wait_results_done();
          end
        end
      end
      drain();
      program_random_regs();
    end

    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
